// ----- sv/lpcrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpcrc_pkg
// shared types and constants of the length-prefixed crc-32 record checker
// ----------------------------------------------------------------------------
package lpcrc_pkg;

  // default largest record body length, in bytes
  localparam int MAX_RECORD_LEN_DEF = 1024;
  // default depth of the result queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;
  // reset value of the highest known event type register
  localparam logic [7:0] HKT_RESET = 8'd3;

  // register index of highest_known_type
  localparam logic REG_HKT = 1'b0;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC_ERR  = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_BAD_LEN  = 3'd4
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] event_number;
    logic [7:0]  record_type;
    logic [9:0]  payload_length;
    status_t     status;
  } rec_item_t;

endpackage
`default_nettype wire

// ----- sv/lpcrc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpcrc_front
// record parser: crc update, field capture, payload pass-through, summaries
// ----------------------------------------------------------------------------
module lpcrc_front #(
  parameter int MAX_RECORD_LEN = lpcrc_pkg::MAX_RECORD_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 end_of_buffer,
  input  wire logic [7:0]           highest_known_type,
  output logic                      push,
  output lpcrc_pkg::rec_item_t      push_item
);

  localparam int REM_W = (MAX_RECORD_LEN > 2) ? $clog2(MAX_RECORD_LEN) : 1;
  localparam logic [31:0] MAX_LEN32 = 32'(MAX_RECORD_LEN);
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  typedef enum logic [4:0] {
    PH_LEN  = 5'b00001,
    PH_NUM  = 5'b00010,
    PH_TYPE = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_CRC  = 5'b10000
  } phase_t;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [REM_W-1:0]  remain_r, remain_nxt;
  logic [9:0]        plen_r, plen_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       num_r, num_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [31:0]       rcrc_r, rcrc_nxt;
  logic              disc_r, disc_nxt;

  logic [31:0]       crc_upd;
  logic [31:0]       len_shift;
  logic [31:0]       len_diff;
  logic              len_bad;
  logic [9:0]        plen_calc;
  logic              new_rec;
  logic              trunc_ok;
  lpcrc_pkg::status_t end_status;

  always_comb begin
    crc_upd   = crc_next(crc_r, data_byte);
    len_shift = {len_r[23:0], data_byte};
    len_diff  = len_shift - 32'd5;
    len_bad   = (len_shift < 32'd5) || (len_shift > MAX_LEN32);
    plen_calc = (|len_diff[31:10]) ? 10'h3FF : len_diff[9:0];
    if (rcrc_r[23:0] != ~crc_r[31:8] || data_byte != ~crc_r[7:0]) begin
      end_status = lpcrc_pkg::ST_CRC_ERR;
    end else if (type_r > highest_known_type) begin
      end_status = lpcrc_pkg::ST_BAD_TYPE;
    end else begin
      end_status = lpcrc_pkg::ST_OK;
    end

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    plen_nxt   = plen_r;
    crc_nxt    = crc_r;
    num_nxt    = num_r;
    type_nxt   = type_r;
    rcrc_nxt   = rcrc_r;
    disc_nxt   = disc_r;
    new_rec    = 1'b0;
    trunc_ok   = 1'b1;
    push       = 1'b0;
    push_item.kind           = lpcrc_pkg::KIND_SUMMARY;
    push_item.payload_byte   = data_byte;
    push_item.event_number   = '0;
    push_item.record_type    = '0;
    push_item.payload_length = '0;
    push_item.status         = lpcrc_pkg::ST_OK;

    if (take) begin
      if (disc_r) begin
        // drop bytes until the buffer ends
        if (end_of_buffer) begin
          disc_nxt = 1'b0;
          new_rec  = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_LEN: begin
            crc_nxt = crc_upd;
            len_nxt = len_shift;
            pos_nxt = pos_r + 2'd1;
            if (pos_r == 2'd3) begin
              if (len_bad) begin
                push             = 1'b1;
                push_item.status = lpcrc_pkg::ST_BAD_LEN;
                disc_nxt         = !end_of_buffer;
                new_rec          = 1'b1;
                trunc_ok         = 1'b0;
              end else begin
                phase_nxt  = PH_NUM;
                pos_nxt    = 2'd0;
                remain_nxt = len_diff[REM_W-1:0];
                plen_nxt   = plen_calc;
              end
            end
          end
          PH_NUM: begin
            crc_nxt = crc_upd;
            num_nxt = {num_r[23:0], data_byte};
            pos_nxt = pos_r + 2'd1;
            if (pos_r == 2'd3) begin
              phase_nxt = PH_TYPE;
              pos_nxt   = 2'd0;
            end
          end
          PH_TYPE: begin
            crc_nxt   = crc_upd;
            type_nxt  = data_byte;
            phase_nxt = (remain_r == '0) ? PH_CRC : PH_PAY;
            pos_nxt   = 2'd0;
          end
          PH_PAY: begin
            crc_nxt = crc_upd;
            if (!end_of_buffer) begin
              push           = 1'b1;
              push_item.kind = lpcrc_pkg::KIND_PAYLOAD;
            end
            remain_nxt = remain_r - REM_W'(1);
            if (remain_r == REM_W'(1)) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            rcrc_nxt = {rcrc_r[23:0], data_byte};
            pos_nxt  = pos_r + 2'd1;
            if (pos_r == 2'd3) begin
              push                     = 1'b1;
              push_item.event_number   = num_r;
              push_item.record_type    = type_r;
              push_item.payload_length = plen_r;
              push_item.status         = end_status;
              disc_nxt = (end_status != lpcrc_pkg::ST_OK) && !end_of_buffer;
              new_rec  = 1'b1;
              trunc_ok = 1'b0;
            end
          end
          default: begin
            phase_nxt = PH_LEN;
          end
        endcase

        // buffer ended inside a record
        if (end_of_buffer && trunc_ok) begin
          push                     = 1'b1;
          push_item.kind           = lpcrc_pkg::KIND_SUMMARY;
          push_item.event_number   = num_nxt;
          push_item.record_type    = type_nxt;
          push_item.payload_length = plen_nxt;
          push_item.status         = lpcrc_pkg::ST_TRUNC;
          new_rec                  = 1'b1;
        end
      end

      if (new_rec) begin
        phase_nxt  = PH_LEN;
        pos_nxt    = 2'd0;
        len_nxt    = '0;
        remain_nxt = '0;
        plen_nxt   = '0;
        crc_nxt    = '1;
        num_nxt    = '0;
        type_nxt   = '0;
        rcrc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      pos_r    <= 2'd0;
      len_r    <= '0;
      remain_r <= '0;
      plen_r   <= '0;
      crc_r    <= '1;
      num_r    <= '0;
      type_r   <= '0;
      rcrc_r   <= '0;
      disc_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      plen_r   <= plen_nxt;
      crc_r    <= crc_nxt;
      num_r    <= num_nxt;
      type_r   <= type_nxt;
      rcrc_r   <= rcrc_nxt;
      disc_r   <= disc_nxt;
    end
  end

  // nothing comes out of a dropped byte
  a_disc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (disc_r && take) |-> !push)
    else $error("result produced while discarding");

  // payload bytes only during the payload phase
  a_pay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_item.kind == lpcrc_pkg::KIND_PAYLOAD) |-> (phase_r == PH_PAY && take))
    else $error("payload byte outside payload phase");

endmodule
`default_nettype wire

// ----- sv/lpcrc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpcrc_queue
// short result queue between parser and output stage
// ----------------------------------------------------------------------------
module lpcrc_queue #(
  parameter int DEPTH = lpcrc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lpcrc_pkg::rec_item_t push_item,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      not_empty,
  output lpcrc_pkg::rec_item_t      head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpcrc_pkg::rec_item_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- sv/lpcrc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpcrc_back
// output stage: formats queued results and holds them for the receiver
// ----------------------------------------------------------------------------
module lpcrc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_not_empty,
  input  wire lpcrc_pkg::rec_item_t q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lpcrc_pkg::rec_item_t      out_item
);

  logic                 valid_r, valid_nxt;
  lpcrc_pkg::rec_item_t item_r;
  lpcrc_pkg::rec_item_t item_fmt;

  assign q_pop     = q_not_empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    item_fmt = q_item;
    if (q_item.kind == lpcrc_pkg::KIND_PAYLOAD) begin
      item_fmt.event_number   = '0;
      item_fmt.record_type    = '0;
      item_fmt.payload_length = '0;
      item_fmt.status         = lpcrc_pkg::ST_OK;
    end else begin
      item_fmt.payload_byte = '0;
    end

    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= item_fmt;
    end
  end

  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && item_r.kind == lpcrc_pkg::KIND_PAYLOAD) |->
      (item_r.status == lpcrc_pkg::ST_OK && item_r.event_number == '0))
    else $error("payload transfer carries summary fields");

endmodule
`default_nettype wire

// ----- sv/length_prefixed_crc32_record_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_crc32_record_checker
// checks length-prefixed records with trailing crc-32, passes payload bytes
// ----------------------------------------------------------------------------
// result path: the front pushes each result into the queue on its input
//   transfer, and the back moves it to the out_* register once that is free
// throughput: one byte per cycle while in_stall is low; the byte-wise crc
//   update sets the cycle. in_stall rises only while the result queue is full
// reset (rst_n low, synchronous): parser back to the length field, queue and
//   output emptied, highest_known_type back to 3
module length_prefixed_crc32_record_checker #(
  parameter int MAX_RECORD_LEN = lpcrc_pkg::MAX_RECORD_LEN_DEF,
  parameter int QUEUE_DEPTH    = lpcrc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_event_number,
  output logic [7:0]       out_record_type,
  output logic [9:0]       out_payload_length,
  output logic [2:0]       out_status,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // config register; word index is paddr[2], low address bits ignored
  logic [7:0] hkt_r, hkt_nxt;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lpcrc_pkg::REG_HKT);
  assign prdata = (paddr[2] == lpcrc_pkg::REG_HKT) ? {24'b0, hkt_r} : 32'b0;

  always_comb begin
    hkt_nxt = hkt_r;
    if (cfg_wr) begin
      hkt_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hkt_r <= lpcrc_pkg::HKT_RESET;
    end else begin
      hkt_r <= hkt_nxt;
    end
  end

  // input transfer happens whenever the queue has room
  logic                 q_full;
  logic                 take;
  logic                 push;
  lpcrc_pkg::rec_item_t push_item;
  logic                 q_pop;
  logic                 q_not_empty;
  lpcrc_pkg::rec_item_t q_item;
  lpcrc_pkg::rec_item_t out_item;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // front: parser and crc
  lpcrc_front #(
    .MAX_RECORD_LEN (MAX_RECORD_LEN)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .take               (take),
    .data_byte          (in_data_byte),
    .end_of_buffer      (in_end_of_buffer),
    .highest_known_type (hkt_r),
    .push               (push),
    .push_item          (push_item)
  );

  // decoupling queue; each byte gives at most one result
  lpcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (q_item)
  );

  // back: output register
  lpcrc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  assign out_kind           = out_item.kind;
  assign out_payload_byte   = out_item.payload_byte;
  assign out_event_number   = out_item.event_number;
  assign out_record_type    = out_item.record_type;
  assign out_payload_length = out_item.payload_length;
  assign out_status         = out_item.status;

  // a transfer into the parser always finds room in the queue
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (take && (!q_full || q_pop)))
    else $error("result without input transfer or queue room");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the length-prefixed crc-32 record checker: builds
// byte buffers of records (good, corrupted, truncated, bad length, junk),
// predicts every payload transfer and record summary, and compares them
// field by field with what the block emits
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          MAX_LEN       = lpcrc_pkg::MAX_RECORD_LEN_DEF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [2:0]  HKT_ADDR      = 3'(4 * int'(lpcrc_pkg::REG_HKT));
  localparam int          SETTLE_CYCLES = 12;
  localparam int          LONG_HOLD     = 150;

  typedef enum logic [4:0] {
    PH_LENGTH  = 5'b00001,
    PH_NUMBER  = 5'b00010,
    PH_TYPE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_TRAILER = 5'b10000
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } stream_byte_t;

  // dut inputs start known at time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [31:0] out_event_number;
  logic [7:0]  out_record_type;
  logic [9:0]  out_payload_length;
  logic [2:0]  out_status;
  logic [31:0] prdata;
  logic        pready;

  // byte stream waiting to be sent, and results the parser copy predicts
  stream_byte_t         pending_bytes[$];
  lpcrc_pkg::rec_item_t predicted_results[$];

  // parser copy of the block
  parse_phase_t parse_state;
  int unsigned  field_pos;
  logic [31:0]  rec_len;
  logic [31:0]  crc_acc;
  logic [31:0]  held_number;
  logic [7:0]   held_type;
  logic [31:0]  rx_crc;
  bit           dropping;
  logic [7:0]   type_limit;

  // driver and monitor bookkeeping
  int                   send_gap = 0;
  bit                   send_quiet = 1'b0;
  stream_byte_t         next_byte;
  lpcrc_pkg::rec_item_t next_result;
  int                   stall_left = 0;
  int                   hold_left = 0;
  bit                   take_quiet = 1'b0;
  int                   results_taken = 0;
  lpcrc_pkg::rec_item_t oldest_result;
  int                   error_count = 0;

  length_prefixed_crc32_record_checker #(
    .MAX_RECORD_LEN(MAX_LEN)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_buffer  (in_end_of_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_event_number  (out_event_number),
    .out_record_type   (out_record_type),
    .out_payload_length(out_payload_length),
    .out_status        (out_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // crc and parser copy
  // ---------------------------------------------------------------------------

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void start_record();
    parse_state = PH_LENGTH;
    field_pos   = 0;
    rec_len     = '0;
    crc_acc     = '1;
    held_number = '0;
    held_type   = '0;
    rx_crc      = '0;
  endfunction

  function automatic void reset_parser();
    type_limit = lpcrc_pkg::HKT_RESET;
    dropping   = 1'b0;
    start_record();
  endfunction

  // body length minus number and type, clipped to the 10-bit field
  function automatic logic [9:0] payload_len();
    if (rec_len < 5) return 10'd0;
    if (rec_len - 5 > 1023) return 10'd1023;
    return 10'(rec_len - 5);
  endfunction

  function automatic lpcrc_pkg::rec_item_t make_summary(input lpcrc_pkg::status_t st,
                                                        input logic [9:0] plen);
    lpcrc_pkg::rec_item_t r;
    r = '0;
    r.kind           = lpcrc_pkg::KIND_SUMMARY;
    r.event_number   = held_number;
    r.record_type    = held_type;
    r.payload_length = plen;
    r.status         = st;
    return r;
  endfunction

  // advances the parser copy by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic eob,
                                    output lpcrc_pkg::rec_item_t res);
    lpcrc_pkg::status_t st;
    res = '0;
    // after an error everything up to the buffer end is dropped silently
    if (dropping) begin
      if (eob) begin
        dropping = 1'b0;
        start_record();
      end
      return 1'b0;
    end
    case (parse_state)
      PH_LENGTH: begin
        crc_acc = crc32_byte(crc_acc, b);
        rec_len = {rec_len[23:0], b};
        field_pos++;
        if (field_pos >= 4) begin
          // bad length is reported at once, even on the last byte of a buffer
          if (rec_len < 5 || rec_len > MAX_LEN) begin
            held_number = '0;
            held_type   = '0;
            res = make_summary(lpcrc_pkg::ST_BAD_LEN, 10'd0);
            dropping = !eob;
            start_record();
            return 1'b1;
          end
          parse_state = PH_NUMBER;
          field_pos   = 0;
        end
      end
      PH_NUMBER: begin
        crc_acc = crc32_byte(crc_acc, b);
        held_number = {held_number[23:0], b};
        field_pos++;
        if (field_pos >= 4) begin
          parse_state = PH_TYPE;
          field_pos   = 0;
        end
      end
      PH_TYPE: begin
        crc_acc = crc32_byte(crc_acc, b);
        held_type = b;
        parse_state = (rec_len == 5) ? PH_TRAILER : PH_PAYLOAD;
        field_pos = 0;
      end
      PH_PAYLOAD: begin
        crc_acc = crc32_byte(crc_acc, b);
        field_pos++;
        if (field_pos >= rec_len - 5) begin
          parse_state = PH_TRAILER;
          field_pos   = 0;
        end
        // a payload byte on the buffer end becomes a truncation summary instead
        if (!eob) begin
          res.kind         = lpcrc_pkg::KIND_PAYLOAD;
          res.payload_byte = b;
          return 1'b1;
        end
      end
      default: begin
        rx_crc = {rx_crc[23:0], b};
        field_pos++;
        if (field_pos >= 4) begin
          // crc mismatch wins over an unknown type
          if (rx_crc != ~crc_acc) st = lpcrc_pkg::ST_CRC_ERR;
          else if (held_type > type_limit) st = lpcrc_pkg::ST_BAD_TYPE;
          else st = lpcrc_pkg::ST_OK;
          res = make_summary(st, payload_len());
          dropping = (st != lpcrc_pkg::ST_OK) && !eob;
          start_record();
          return 1'b1;
        end
      end
    endcase
    // buffer ended inside a record
    if (eob) begin
      res = make_summary(lpcrc_pkg::ST_TRUNC,
                         (parse_state == PH_LENGTH) ? 10'd0 : payload_len());
      start_record();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // queues one record; cut >= 0 ends the buffer on that byte index instead
  function automatic int add_record(input logic [31:0] len, input logic [31:0] number,
                                    input logic [7:0] etype, input bit corrupt,
                                    input int cut, input bit end_buf);
    logic [7:0]   rec_bytes[$];
    logic [31:0]  crc;
    int           n;
    stream_byte_t sb;
    for (int k = 3; k >= 0; k--) rec_bytes.push_back(len[8*k +: 8]);
    for (int k = 3; k >= 0; k--) rec_bytes.push_back(number[8*k +: 8]);
    rec_bytes.push_back(etype);
    for (int unsigned k = 5; k < len; k++) rec_bytes.push_back(8'($urandom));
    crc = '1;
    foreach (rec_bytes[i]) crc = crc32_byte(crc, rec_bytes[i]);
    crc = ~crc;
    // single flipped bit in the trailer
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 3; k >= 0; k--) rec_bytes.push_back(crc[8*k +: 8]);
    n = (cut >= 0) ? cut + 1 : rec_bytes.size();
    for (int i = 0; i < n; i++) begin
      sb.data = rec_bytes[i];
      sb.eob  = (i == n - 1) && (end_buf || cut >= 0);
      pending_bytes.push_back(sb);
    end
    return n;
  endfunction

  // four length bytes then junk; the buffer ends on the last byte
  function automatic int add_length_then_junk(input logic [31:0] head, input int tail);
    stream_byte_t sb;
    for (int k = 3; k >= 0; k--) begin
      sb.data = head[8*k +: 8];
      sb.eob  = (k == 0) && (tail == 0);
      pending_bytes.push_back(sb);
    end
    for (int i = 0; i < tail; i++) begin
      sb.data = 8'($urandom);
      sb.eob  = (i == tail - 1);
      pending_bytes.push_back(sb);
    end
    return 4 + tail;
  endfunction

  // mostly short bodies, now and then a longer one
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 64) : $urandom_range(5, 16);
  endfunction

  // types cluster around the low codes so the limit register matters
  function automatic logic [7:0] pick_type();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
  endfunction

  // buffers of one to four records; any error ends the buffer early in practice
  function automatic void queue_random_buffers(input int target);
    int          added;
    int          n_rec;
    int          pick;
    int          body;
    logic [31:0] bad_len;
    added = 0;
    while (added < target) begin
      n_rec = $urandom_range(1, 4);
      for (int r = 0; r < n_rec; r++) begin
        pick = $urandom_range(0, 99);
        body = pick_len();
        if (pick < 55) begin
          added += add_record(body, $urandom, pick_type(), 1'b0, -1, r == n_rec - 1);
        end else if (pick < 67) begin
          added += add_record(body, $urandom, pick_type(), 1'b1, -1, r == n_rec - 1);
        end else if (pick < 75) begin
          added += add_record(body, $urandom, 8'($urandom), 1'b0, -1, r == n_rec - 1);
        end else if (pick < 87) begin
          // buffer ends anywhere from the first length byte to the last crc byte but one
          added += add_record(body, $urandom, pick_type(), 1'b0,
                              $urandom_range(0, body + 6), 1'b1);
          break;
        end else if (pick < 93) begin
          case ($urandom_range(0, 3))
            0:       bad_len = $urandom_range(0, 4);
            1:       bad_len = MAX_LEN + 1;
            2:       bad_len = $urandom_range(MAX_LEN + 1, 32'hFFFF_FFFF);
            default: bad_len = 32'hFFFF_FFFF;
          endcase
          added += add_length_then_junk(bad_len, $urandom_range(0, 6));
          break;
        end else begin
          // plain noise
          added += add_length_then_junk($urandom, $urandom_range(0, 12));
          break;
        end
      end
    end
  endfunction

  // per-transfer wait, with stretches of back-to-back traffic
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 23) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one byte per transfer, prediction taken on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_data_byte     <= '0;
      in_end_of_buffer <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_byte(in_data_byte, in_end_of_buffer, next_result)) begin
          predicted_results.push_back(next_result);
        end
      end
      if (in_valid && in_stall) begin
        // stalled transfer keeps its payload
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_bytes.size() != 0) begin
        next_byte = pending_bytes.pop_front();
        in_valid         <= 1'b1;
        in_data_byte     <= next_byte.data;
        in_end_of_buffer <= next_byte.eob;
        send_gap = draw_wait(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0h byte %0h status %0h",
                   $time, out_kind, out_payload_byte, out_status);
          error_count++;
        end else begin
          oldest_result = predicted_results.pop_front();
          check_field("kind", oldest_result.kind, out_kind);
          check_field("payload_byte", oldest_result.payload_byte, out_payload_byte);
          check_field("event_number", oldest_result.event_number, out_event_number);
          check_field("record_type", oldest_result.record_type, out_record_type);
          check_field("payload_length", oldest_result.payload_length, out_payload_length);
          check_field("status", oldest_result.status, out_status);
        end
        results_taken++;
        // long hold-off lets the result queue fill so the input side backs up
        if (results_taken == 40 || results_taken == 200) hold_left = LONG_HOLD;
        else stall_left = draw_wait(take_quiet);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // waits until every byte is sent and every predicted result has been taken
  task automatic wait_until_idle();
    while (pending_bytes.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write of the type limit: setup, then access
  task automatic set_type_limit(input logic [7:0] limit);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HKT_ADDR;
    pwdata  <= {24'd0, limit};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    type_limit = limit;
  endtask

  initial begin
    reset_parser();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, with the limit at its reset value
    // bad length that is also the last byte of the buffer
    void'(add_length_then_junk(32'h0000_0000, 0));
    // shortest body, all-ones number, unknown type, buffer ends on the crc
    void'(add_record(32'd5, 32'hFFFF_FFFF, 8'hFF, 1'b0, -1, 1'b1));
    // longest possible length field, then dropped bytes to the buffer end
    void'(add_length_then_junk(32'hFFFF_FFFF, 1));
    // buffer ends inside the event number
    void'(add_record(32'd7, 32'h1234_5678, 8'd1, 1'b0, 5, 1'b1));
    wait_until_idle();

    // lowest limit: every nonzero type is unknown
    set_type_limit(8'h00);
    queue_random_buffers(100);
    wait_until_idle();

    // highest limit, plus one longer record
    set_type_limit(8'hFF);
    void'(add_record(32'd120, $urandom, pick_type(), 1'b0, -1, 1'b1));
    queue_random_buffers(100);
    wait_until_idle();

    set_type_limit(8'($urandom_range(1, 254)));
    queue_random_buffers(100);
    wait_until_idle();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
